[sv/urwd_pkg.sv]
// Shared constants and types for the unlocked register write decoder.
// Holds the unlock sequence, the register address map and the decode result struct.
// No dependencies.
`timescale 1ns / 1ps

package urwd_pkg;

  localparam int unsigned ADDR_W    = 28;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned STEP_W    = 3;
  localparam int unsigned NUM_REGS  = 12;
  localparam int unsigned IDX_W     = 4;

  // Step counts at which the bank is locked and unlocked.
  localparam logic [STEP_W-1:0] STEP_LOCKED   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_UNLOCKED = 3'd4;

  // Lock command: this data at this address relocks the bank.
  localparam logic [ADDR_W-1:0] LOCK_ADDR = 28'h9FC0000;
  localparam logic [DATA_W-1:0] LOCK_DATA = 16'h1500;

  // Unlock sequence, one address and data word per step.
  localparam logic [ADDR_W-1:0] SEQ_ADDR [4] = '{
    28'h9FE0000, 28'h8000000, 28'h8020000, 28'h8040000
  };
  localparam logic [DATA_W-1:0] SEQ_DATA [4] = '{
    16'hD200, 16'h1500, 16'hD200, 16'h1500
  };

  // Control register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_SD_CTRL    = 4'd0,
    REG_BUF_CTRL   = 4'd1,
    REG_SECTOR_LO  = 4'd2,
    REG_SECTOR_HI  = 4'd3,
    REG_SD_BLOCK   = 4'd4,
    REG_SPI        = 4'd5,
    REG_SPI_WRITE  = 4'd6,
    REG_RTC        = 4'd7,
    REG_AUTOSAVE   = 4'd8,
    REG_PSRAM_PAGE = 4'd9,
    REG_ROM_PAGE   = 4'd10,
    REG_RAM_PAGE   = 4'd11
  } urwd_reg_idx_t;

  // Bus address of each control register, in index order.
  localparam logic [ADDR_W-1:0] REG_ADDR [NUM_REGS] = '{
    28'h9400000, 28'h9420000, 28'h9600000, 28'h9620000,
    28'h9640000, 28'h9660000, 28'h9680000, 28'h96A0000,
    28'h96C0000, 28'h9860000, 28'h9880000, 28'h9C00000
  };

  // Whole register bank as one packed word.
  typedef logic [NUM_REGS-1:0][DATA_W-1:0] urwd_bank_t;

  // Decode outcome of one bus write.
  typedef struct packed {
    logic [STEP_W-1:0] step_nxt;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
  } urwd_dec_t;

endpackage

[sv/urwd_seq.sv]
// Unlock sequence tracker and register address decoder.
// Depends on urwd_pkg for the sequence, the address map and the decode struct.
`timescale 1ns / 1ps

module urwd_seq
  import urwd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] data,
  output urwd_dec_t         dec
);

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic              unlocked;
  logic [1:0]        s;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;

  assign unlocked = (step_r >= STEP_UNLOCKED);
  assign s        = step_r[1:0];

  // Match the address against the register map; addresses are distinct.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = NUM_REGS - 1; i >= 0; i--) begin
      if (addr == REG_ADDR[i]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  // Next sequence step and register write decision.
  always_comb begin
    step_nxt = step_r;
    dec.wr_en  = 1'b0;
    dec.wr_idx = '0;
    if (unlocked) begin
      if (addr == LOCK_ADDR && data == LOCK_DATA) begin
        step_nxt = STEP_LOCKED;
      end else if (hit) begin
        dec.wr_en  = 1'b1;
        dec.wr_idx = hit_idx;
      end
    end else begin
      if (addr == SEQ_ADDR[s] && data == SEQ_DATA[s]) begin
        step_nxt = {1'b0, s} + STEP_W'(1);
      end else if (addr == SEQ_ADDR[0] && data == SEQ_DATA[0]) begin
        step_nxt = STEP_W'(1);
      end else begin
        step_nxt = STEP_LOCKED;
      end
    end
    dec.step_nxt = step_nxt;
  end

  // Step register takes the next step once per decoded beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_LOCKED;
    end else if (fire) begin
      step_r <= step_nxt;
    end
  end

  // The step never passes the unlocked count.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_UNLOCKED)
    else $error("sequence step out of range");

  // A register write is only decoded while unlocked, and it keeps the bank unlocked.
  a_write_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
    dec.wr_en |-> (unlocked && dec.step_nxt == STEP_UNLOCKED))
    else $error("register write decoded while locked");

  // While locked, a beat moves the step by at most one.
  a_step_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !unlocked) |=> (step_r <= $past(step_r) + STEP_W'(1)))
    else $error("sequence step skipped ahead");

endmodule

[sv/urwd_regbank.sv]
// Bank of twelve 16-bit control registers written by decoded bus beats.
// Depends on urwd_pkg for the bank type and the decode struct.
`timescale 1ns / 1ps

module urwd_regbank
  import urwd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  urwd_dec_t         dec,
  input  logic [DATA_W-1:0] data,
  output urwd_bank_t        bank_nxt
);

  urwd_bank_t regs_r;

  // Contents after the current beat: the written entry takes the bus data.
  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      if (dec.wr_en && dec.wr_idx == IDX_W'(i)) begin
        bank_nxt[i] = data;
      end else begin
        bank_nxt[i] = regs_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else if (fire) begin
      regs_r <= bank_nxt;
    end
  end

  // A latched write lands in the addressed register.
  a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && dec.wr_en) |=> (regs_r[$past(dec.wr_idx)] == $past(data)))
    else $error("register write did not land");

endmodule

[sv/unlocked_register_write_decoder.sv]
// Top level of the unlocked register write decoder.
// Depends on urwd_pkg, urwd_seq and urwd_regbank.
// Each bus write beat is taken into an input register, decoded against the
// unlock sequence and the register map combinationally, and its result is held in
// an output register. One beat is accepted per cycle while in_stall is low; a beat
// passes from acceptance through the input register and then the result register.
// in_stall rises only when both registers hold beats and the result is stalled.
// The bank resets locked with all twelve registers at zero.
`timescale 1ns / 1ps

module unlocked_register_write_decoder
  import urwd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ADDR_W-1:0] in_bus_address,
  input  logic [DATA_W-1:0] in_bus_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_unlock_progress,
  output logic              out_reg_written,
  output logic [3:0]        out_reg_index,
  output logic [15:0]       out_reg_value,
  output logic [15:0]       out_rom_page,
  output logic [15:0]       out_psram_page,
  output logic [15:0]       out_ram_page,
  output logic [31:0]       out_sd_sector,
  output logic [14:0]       out_sd_block_count,
  output logic              out_sd_write_dir,
  output logic [15:0]       out_sd_control,
  output logic [15:0]       out_buffer_control
);

  logic              s1_valid_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [DATA_W-1:0] s1_data_r;
  logic              res_free;
  logic              fire;
  urwd_dec_t         dec;
  urwd_bank_t        bank_nxt;

  logic              out_valid_r;
  logic [2:0]        progress_r;
  logic              written_r;
  logic [3:0]        index_r;
  logic [15:0]       value_r;
  logic [15:0]       rom_page_r;
  logic [15:0]       psram_page_r;
  logic [15:0]       ram_page_r;
  logic [31:0]       sector_r;
  logic [15:0]       block_r;
  logic [15:0]       sd_ctrl_r;
  logic [15:0]       buf_ctrl_r;

  // Handshake: the result register frees when it is empty or taken.
  assign res_free = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && res_free;
  assign in_stall = s1_valid_r && !res_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_addr_r <= in_bus_address;
      s1_data_r <= in_bus_data;
    end
  end

  urwd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .addr  (s1_addr_r),
    .data  (s1_data_r),
    .dec   (dec)
  );

  urwd_regbank u_regbank (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .dec      (dec),
    .data     (s1_data_r),
    .bank_nxt (bank_nxt)
  );

  // Result register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Result payload captures the state after the beat.
  always_ff @(posedge clk) begin
    if (fire) begin
      progress_r   <= dec.step_nxt;
      written_r    <= dec.wr_en;
      index_r      <= dec.wr_en ? dec.wr_idx : '0;
      value_r      <= dec.wr_en ? s1_data_r : '0;
      rom_page_r   <= bank_nxt[REG_ROM_PAGE];
      psram_page_r <= bank_nxt[REG_PSRAM_PAGE];
      ram_page_r   <= bank_nxt[REG_RAM_PAGE];
      sector_r     <= {bank_nxt[REG_SECTOR_HI], bank_nxt[REG_SECTOR_LO]};
      block_r      <= bank_nxt[REG_SD_BLOCK];
      sd_ctrl_r    <= bank_nxt[REG_SD_CTRL];
      buf_ctrl_r   <= bank_nxt[REG_BUF_CTRL];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_unlock_progress = progress_r;
  assign out_reg_written     = written_r;
  assign out_reg_index       = index_r;
  assign out_reg_value       = value_r;
  assign out_rom_page        = rom_page_r;
  assign out_psram_page      = psram_page_r;
  assign out_ram_page        = ram_page_r;
  assign out_sd_sector       = sector_r;
  assign out_sd_block_count  = block_r[14:0];
  assign out_sd_write_dir    = block_r[15];
  assign out_sd_control      = sd_ctrl_r;
  assign out_buffer_control  = buf_ctrl_r;

  // A beat without a latch reports a zero index and value.
  a_no_latch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !written_r) |-> (index_r == '0 && value_r == '0))
    else $error("index or value set without a latch");

  // A latch is only reported with the bank unlocked.
  a_latch_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && written_r) |-> (progress_r == STEP_UNLOCKED))
    else $error("latch reported while locked");

  // The input side only stalls while a result is held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && s1_valid_r))
    else $error("input stalled without a held result");

endmodule

[test/urwd_write_checker.sv]
// Checker for the unlocked register write decoder: it watches both channels,
// tracks the unlock sequence and the control register bank, and compares every result beat.
// Depends on urwd_pkg.
`timescale 1ns / 1ps

module urwd_write_checker
  import urwd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [ADDR_W-1:0] in_bus_address,
  input  logic [DATA_W-1:0] in_bus_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [2:0]        out_unlock_progress,
  input  logic              out_reg_written,
  input  logic [3:0]        out_reg_index,
  input  logic [15:0]       out_reg_value,
  input  logic [15:0]       out_rom_page,
  input  logic [15:0]       out_psram_page,
  input  logic [15:0]       out_ram_page,
  input  logic [31:0]       out_sd_sector,
  input  logic [14:0]       out_sd_block_count,
  input  logic              out_sd_write_dir,
  input  logic [15:0]       out_sd_control,
  input  logic [15:0]       out_buffer_control,
  output int                error_count,
  output int                outstanding
);

  // Everything one bus write reports, in the order of the result ports.
  typedef struct packed {
    logic [2:0]  progress;
    logic        written;
    logic [3:0]  index;
    logic [15:0] value;
    logic [15:0] rom_page;
    logic [15:0] psram_page;
    logic [15:0] ram_page;
    logic [31:0] sd_sector;
    logic [14:0] block_count;
    logic        write_dir;
    logic [15:0] sd_control;
    logic [15:0] buffer_control;
  } write_report_t;

  logic [STEP_W-1:0] unlock_step;
  logic [DATA_W-1:0] ctrl_regs [NUM_REGS];
  write_report_t     pending_reports [$];
  int                mismatches = 0;

  // Apply one bus write to the mirrored bank and return the report it should give.
  function automatic write_report_t decode_bus_write(input logic [ADDR_W-1:0] addr,
                                                     input logic [DATA_W-1:0] data);
    write_report_t rep;
    logic [1:0]    step;
    rep = '0;
    if (unlock_step >= STEP_UNLOCKED) begin
      // Unlocked: the lock command wins, otherwise the first matching register latches.
      if (addr == LOCK_ADDR && data == LOCK_DATA) begin
        unlock_step = STEP_LOCKED;
      end else begin
        for (int i = 0; i < NUM_REGS; i++) begin
          if (!rep.written && addr == REG_ADDR[i]) begin
            ctrl_regs[i] = data;
            rep.written  = 1'b1;
            rep.index    = i[3:0];
            rep.value    = data;
          end
        end
      end
    end else begin
      // Locked: a miss restarts the sequence, counting itself if it matches the first step.
      step = unlock_step[1:0];
      if (addr == SEQ_ADDR[step] && data == SEQ_DATA[step])
        unlock_step = STEP_W'(step) + 3'd1;
      else if (addr == SEQ_ADDR[0] && data == SEQ_DATA[0])
        unlock_step = STEP_LOCKED + 3'd1;
      else
        unlock_step = STEP_LOCKED;
    end
    rep.progress       = unlock_step;
    rep.rom_page       = ctrl_regs[REG_ROM_PAGE];
    rep.psram_page     = ctrl_regs[REG_PSRAM_PAGE];
    rep.ram_page       = ctrl_regs[REG_RAM_PAGE];
    rep.sd_sector      = {ctrl_regs[REG_SECTOR_HI], ctrl_regs[REG_SECTOR_LO]};
    rep.block_count    = ctrl_regs[REG_SD_BLOCK][14:0];
    rep.write_dir      = ctrl_regs[REG_SD_BLOCK][15];
    rep.sd_control     = ctrl_regs[REG_SD_CTRL];
    rep.buffer_control = ctrl_regs[REG_BUF_CTRL];
    return rep;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare the result beat first, since it always belongs to an earlier write beat.
  always @(posedge clk) begin
    write_report_t seen;
    write_report_t want;
    if (!rst_n) begin
      unlock_step = STEP_LOCKED;
      for (int i = 0; i < NUM_REGS; i++) ctrl_regs[i] = '0;
      pending_reports.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen = {out_unlock_progress, out_reg_written, out_reg_index, out_reg_value,
                out_rom_page, out_psram_page, out_ram_page, out_sd_sector,
                out_sd_block_count, out_sd_write_dir, out_sd_control, out_buffer_control};
        if (pending_reports.size() == 0) begin
          $error("Result beat with no write waiting (progress %0d)", out_unlock_progress);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          check_field("unlock_progress", 32'(want.progress), 32'(seen.progress));
          check_field("reg_written", 32'(want.written), 32'(seen.written));
          check_field("reg_index", 32'(want.index), 32'(seen.index));
          check_field("reg_value", 32'(want.value), 32'(seen.value));
          check_field("rom_page", 32'(want.rom_page), 32'(seen.rom_page));
          check_field("psram_page", 32'(want.psram_page), 32'(seen.psram_page));
          check_field("ram_page", 32'(want.ram_page), 32'(seen.ram_page));
          check_field("sd_sector", want.sd_sector, seen.sd_sector);
          check_field("sd_block_count", 32'(want.block_count), 32'(seen.block_count));
          check_field("sd_write_dir", 32'(want.write_dir), 32'(seen.write_dir));
          check_field("sd_control", 32'(want.sd_control), 32'(seen.sd_control));
          check_field("buffer_control", 32'(want.buffer_control),
                      32'(seen.buffer_control));
        end
      end
      if (in_valid && !in_stall)
        pending_reports.push_back(decode_bus_write(in_bus_address, in_bus_data));
    end
    error_count <= mismatches;
    outstanding <= pending_reports.size();
  end

endmodule

[test/unlocked_register_write_decoder_test.sv]
// Testbench top for the unlocked register write decoder: drives bus write beats and
// result stalls through several idling phases and gives the verdict.
// Depends on urwd_pkg, urwd_write_checker and the decoder itself.
`timescale 1ns / 1ps

module unlocked_register_write_decoder_test;
  import urwd_pkg::*;

  localparam int CLK_PERIOD       = 12;
  localparam int RESET_CYCLES     = 4;
  localparam int WRITES_PER_PHASE = 125;
  localparam int DRAIN_CYCLES     = 8;
  localparam int WATCHDOG_LIMIT   = 4000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ADDR_W-1:0] in_bus_address = '0;
  logic [DATA_W-1:0] in_bus_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        out_unlock_progress;
  logic              out_reg_written;
  logic [3:0]        out_reg_index;
  logic [15:0]       out_reg_value;
  logic [15:0]       out_rom_page;
  logic [15:0]       out_psram_page;
  logic [15:0]       out_ram_page;
  logic [31:0]       out_sd_sector;
  logic [14:0]       out_sd_block_count;
  logic              out_sd_write_dir;
  logic [15:0]       out_sd_control;
  logic [15:0]       out_buffer_control;
  int                error_count;
  int                outstanding;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int writes_sent = 0;
  int quiet_cycles = 0;

  unlocked_register_write_decoder DUT (.*);

  urwd_write_checker write_checker (.*);

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // The result side stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: too long without any beat on either channel ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Send one write beat, with random idle cycles ahead of it, and wait for acceptance.
  task automatic bus_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_bus_address <= addr;
    in_bus_data    <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    writes_sent++;
  endtask

  // Walk the unlock sequence; with some chance one step is replaced by a stray write that ends the walk.
  task automatic unlock_bank(input int break_pct);
    int bad_step;
    bad_step = ($urandom_range(99) < break_pct) ? int'($urandom_range(3)) : 4;
    for (int s = 0; s < 4; s++) begin
      if (s == bad_step) begin
        if ($urandom_range(1))
          bus_write(SEQ_ADDR[s], pick_data());
        else
          bus_write(pick_address(), pick_data());
        return;
      end
      bus_write(SEQ_ADDR[s], SEQ_DATA[s]);
    end
  endtask

  // Addresses lean on the decoded ones, with near misses and plain noise mixed in.
  function automatic logic [ADDR_W-1:0] pick_address();
    case ($urandom_range(9))
      0, 1, 2, 3: return REG_ADDR[$urandom_range(NUM_REGS - 1)];
      4:          return SEQ_ADDR[$urandom_range(3)];
      5:          return LOCK_ADDR;
      6:          return REG_ADDR[$urandom_range(NUM_REGS - 1)] ^
                         (28'd1 << $urandom_range(ADDR_W - 1));
      7:          return 28'h8000000 + 28'($urandom_range(28'h1FFFFFF));
      8:          return 28'($urandom);
      default:    return 28'h8000000 | (28'($urandom_range(255)) << 17);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return SEQ_DATA[0];
      3:       return LOCK_DATA;
      4:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int phase_end;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: unlock, touch every register with extreme data, then the odd cases.
    unlock_bank(0);
    for (int i = 0; i < NUM_REGS; i++)
      bus_write(REG_ADDR[i], (i % 2) ? 16'hFFFF : 16'h8000);
    bus_write(LOCK_ADDR, SEQ_DATA[0]);
    bus_write(28'h9FFFFFF, 16'hFFFF);
    bus_write(REG_ADDR[REG_SD_BLOCK], 16'h7FFF);
    bus_write(LOCK_ADDR, LOCK_DATA);
    bus_write(REG_ADDR[REG_ROM_PAGE], 16'h0000);
    // A repeated first step restarts at step one; a bad data word drops back to zero.
    bus_write(SEQ_ADDR[0], SEQ_DATA[0]);
    bus_write(SEQ_ADDR[0], SEQ_DATA[0]);
    bus_write(SEQ_ADDR[1], SEQ_DATA[1]);
    bus_write(SEQ_ADDR[2], 16'h0000);

    // Random: mostly unlock, a burst of writes, then usually a relock; some pure noise.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      phase_end = writes_sent + WRITES_PER_PHASE;
      while (writes_sent < phase_end) begin
        if ($urandom_range(99) < 70) begin
          unlock_bank(15);
          repeat ($urandom_range(1, 12)) bus_write(pick_address(), pick_data());
          if ($urandom_range(3) != 0) bus_write(LOCK_ADDR, LOCK_DATA);
        end else begin
          repeat ($urandom_range(1, 4)) bus_write(pick_address(), pick_data());
        end
      end
    end

    // Drain: let the checker see the last write, wait for every result, then settle.
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
